// ----- rtl/core/wsfd_pkg.sv -----
// ----------------------------------------------------------------------------
// wsfd_pkg
// Shared types and constants for the websocket frame deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package wsfd_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned OpW   = 4;
  localparam int unsigned LenW  = 64;
  localparam int unsigned CntW  = 4;

  localparam logic [6:0] Len7Mask = 7'h7F;
  localparam logic [6:0] LenExt16 = 7'd126;
  localparam logic [6:0] LenExt64 = 7'd127;

  // extended length byte counts
  localparam logic [CntW-1:0] Ext16Bytes = 4'd2;
  localparam logic [CntW-1:0] Ext64Bytes = 4'd8;

  typedef enum logic [1:0] {
    PH_FIRST   = 2'd0,
    PH_SECOND  = 2'd1,
    PH_EXT     = 2'd2,
    PH_PAYLOAD = 2'd3
  } phase_t;

  typedef enum logic {
    KIND_HEADER  = 1'b0,
    KIND_PAYLOAD = 1'b1
  } rec_kind_t;

  typedef struct packed {
    rec_kind_t             kind;
    logic [OpW-1:0]        opcode;
    logic [LenW-1:0]       length;
    logic [ByteW-1:0]      data;
    logic                  last;
  } rec_t;

endpackage

`default_nettype wire

// ----- rtl/core/wsfd_out_buf.sv -----
// ----------------------------------------------------------------------------
// wsfd_out_buf
// Two-entry result buffer: output register plus skid entry.
// ----------------------------------------------------------------------------
`default_nettype none

module wsfd_out_buf (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire wsfd_pkg::rec_t push_rec,
  output logic                full,
  output logic                out_valid,
  input  wire logic           out_ready,
  output wsfd_pkg::rec_t      out_rec
);

  wsfd_pkg::rec_t e0_r, e0_nxt;
  wsfd_pkg::rec_t e1_r, e1_nxt;
  logic [1:0]     cnt_r, cnt_nxt;
  logic           pop;

  assign pop       = (cnt_r != 2'd0) && out_ready;
  assign full      = (cnt_r == 2'd2);
  assign out_valid = (cnt_r != 2'd0);
  assign out_rec   = e0_r;

  always_comb begin
    e0_nxt  = e0_r;
    e1_nxt  = e1_r;
    cnt_nxt = cnt_r;
    if (pop) begin
      e0_nxt = e1_r;
    end
    if (push) begin
      // new request lands behind whatever stays after the pop
      if ((cnt_r == 2'd0) || (pop && (cnt_r == 2'd1))) begin
        e0_nxt = push_rec;
      end else begin
        e1_nxt = push_rec;
      end
    end
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    e0_r <= e0_nxt;
    e1_r <= e1_nxt;
  end

endmodule

`default_nettype wire

// ----- rtl/core/websocket_frame_deframer_unit.sv -----
// ----------------------------------------------------------------------------
// websocket_frame_deframer_unit
// Splits a received byte stream into websocket frame header and payload
// results, one byte per cycle while the output buffer is not full.
// ----------------------------------------------------------------------------
// output: each result is registered in the output buffer before it is visible.
// throughput: one byte per cycle while the output buffer is not full;
//   a two-entry output buffer keeps input ready while a result waits.
// reset: synchronous active-low rst_n returns the parser to the first
//   header byte and empties the output buffer.
`default_nettype none

module websocket_frame_deframer_unit (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [wsfd_pkg::ByteW-1:0]   in_rx_byte,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic                              out_rec_kind,
  output logic [wsfd_pkg::OpW-1:0]          out_opcode,
  output logic [wsfd_pkg::LenW-1:0]         out_payload_length,
  output logic [wsfd_pkg::ByteW-1:0]        out_data_byte,
  output logic                              out_last_of_frame
);

  wsfd_pkg::phase_t               phase_r, phase_nxt;
  logic [wsfd_pkg::CntW-1:0]      ext_cnt_r, ext_cnt_nxt;
  logic [wsfd_pkg::LenW-1:0]      len_r, len_nxt;
  logic [wsfd_pkg::LenW-1:0]      rem_r, rem_nxt;
  logic [wsfd_pkg::OpW-1:0]       opcode_r, opcode_nxt;

  logic                           accept;
  logic                           buf_full;
  logic                           push;
  wsfd_pkg::rec_t                 rec;
  wsfd_pkg::rec_t                 out_rec;

  logic [6:0]                     len7;
  logic                           len_is_ext;
  logic [wsfd_pkg::LenW-1:0]      ext_len;
  logic [wsfd_pkg::CntW-1:0]      ext_cnt_dec;
  logic [wsfd_pkg::LenW-1:0]      rem_dec;

  assign in_ready = !buf_full;
  assign accept   = in_valid && in_ready;

  assign len7        = in_rx_byte[6:0] & wsfd_pkg::Len7Mask;
  assign len_is_ext  = (len7 == wsfd_pkg::LenExt16) || (len7 == wsfd_pkg::LenExt64);
  assign ext_len     = {len_r[wsfd_pkg::LenW-wsfd_pkg::ByteW-1:0], in_rx_byte};
  assign ext_cnt_dec = ext_cnt_r - 4'd1;
  assign rem_dec     = rem_r - 64'd1;

  // next state
  always_comb begin
    phase_nxt   = phase_r;
    ext_cnt_nxt = ext_cnt_r;
    len_nxt     = len_r;
    rem_nxt     = rem_r;
    opcode_nxt  = opcode_r;
    if (accept) begin
      case (phase_r)
        wsfd_pkg::PH_SECOND: begin
          if (len_is_ext) begin
            ext_cnt_nxt = (len7 == wsfd_pkg::LenExt16) ? wsfd_pkg::Ext16Bytes
                                                       : wsfd_pkg::Ext64Bytes;
            len_nxt     = '0;
            phase_nxt   = wsfd_pkg::PH_EXT;
          end else begin
            len_nxt    = {57'd0, len7};
            rem_nxt    = {57'd0, len7};
            phase_nxt  = (len7 == 7'd0) ? wsfd_pkg::PH_FIRST : wsfd_pkg::PH_PAYLOAD;
          end
        end
        wsfd_pkg::PH_EXT: begin
          len_nxt     = ext_len;
          ext_cnt_nxt = ext_cnt_dec;
          if (ext_cnt_dec == 4'd0) begin
            rem_nxt    = ext_len;
            phase_nxt  = (ext_len == 64'd0) ? wsfd_pkg::PH_FIRST : wsfd_pkg::PH_PAYLOAD;
          end
        end
        wsfd_pkg::PH_PAYLOAD: begin
          rem_nxt  = rem_dec;
          if (rem_dec == 64'd0) begin
            phase_nxt = wsfd_pkg::PH_FIRST;
          end
        end
        default: begin
          opcode_nxt  = in_rx_byte[wsfd_pkg::OpW-1:0];
          ext_cnt_nxt = '0;
          len_nxt     = '0;
          rem_nxt     = '0;
          phase_nxt   = wsfd_pkg::PH_SECOND;
        end
      endcase
    end
  end

  // result for the accepted byte
  always_comb begin
    push        = 1'b0;
    rec.kind    = wsfd_pkg::KIND_HEADER;
    rec.opcode  = opcode_r;
    rec.length  = len_r;
    rec.data    = '0;
    rec.last    = 1'b0;
    if (accept) begin
      case (phase_r)
        wsfd_pkg::PH_SECOND: begin
          if (!len_is_ext) begin
            push       = 1'b1;
            rec.length = {57'd0, len7};
            rec.last   = (len7 == 7'd0);
          end
        end
        wsfd_pkg::PH_EXT: begin
          if (ext_cnt_dec == 4'd0) begin
            push       = 1'b1;
            rec.length = ext_len;
            rec.last   = (ext_len == 64'd0);
          end
        end
        wsfd_pkg::PH_PAYLOAD: begin
          push     = 1'b1;
          rec.kind = wsfd_pkg::KIND_PAYLOAD;
          rec.data = in_rx_byte;
          rec.last = (rem_dec == 64'd0);
        end
        default: begin
          push = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= wsfd_pkg::PH_FIRST;
      ext_cnt_r <= '0;
      len_r     <= '0;
      rem_r     <= '0;
      opcode_r  <= '0;
    end else begin
      phase_r   <= phase_nxt;
      ext_cnt_r <= ext_cnt_nxt;
      len_r     <= len_nxt;
      rem_r     <= rem_nxt;
      opcode_r  <= opcode_nxt;
    end
  end

  wsfd_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_rec  (rec),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_rec   (out_rec)
  );

  assign out_rec_kind       = out_rec.kind;
  assign out_opcode         = out_rec.opcode;
  assign out_payload_length = out_rec.length;
  assign out_data_byte      = out_rec.data;
  assign out_last_of_frame  = out_rec.last;

endmodule

`default_nettype wire
